FILE: hw/rtl/fpuv_pkg.sv
// ----------------------------------------------------------------------------
// fpuv_pkg
// shared constants, pipeline item type and helpers of the fisheye uv projector
// ----------------------------------------------------------------------------
package fpuv_pkg;

	localparam int NUM_CAMERAS = 4;
	localparam int COEF_SLOTS  = 32;
	localparam int USED_SLOTS  = 23;
	localparam int CAM_IW      = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
	localparam int FRAC        = 20;

	// request functions
	localparam logic FUNC_WRITE   = 1'b0;
	localparam logic FUNC_PROJECT = 1'b1;

	// calibration word slots
	localparam int SLOT_XI = 12;
	localparam int SLOT_K1 = 13;
	localparam int SLOT_K2 = 14;
	localparam int SLOT_P1 = 15;
	localparam int SLOT_P2 = 16;
	localparam int SLOT_FX = 17;
	localparam int SLOT_FY = 18;
	localparam int SLOT_CX = 19;
	localparam int SLOT_CY = 20;
	localparam int SLOT_WD = 21;
	localparam int SLOT_HT = 22;

	// pipeline depths of the iterative units
	localparam int SQRT_STEPS = 32;
	localparam int XDIV_STEPS = 21;
	localparam int UDIV_STEPS = 17;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef logic [CAM_IW-1:0] cam_idx_t;

	typedef struct packed {
		logic [1:0]                  cam;
		logic                        bad;
		logic [USED_SLOTS-1:0][31:0] w;
		logic signed [32:0]          wx;
		logic signed [31:0]          wy;
		logic signed [31:0]          wz;
		logic [8:0][44:0]            prod;
		logic [2:0][27:0]            tr;
		logic [2:0][31:0]            c;
		logic [2:0][62:0]            sq3;
		logic [63:0]                 sq;
		logic [31:0]                 root;
		logic signed [44:0]          xip;
		logic [45:0]                 dmag;
		logic [1:0]                  neg;
		logic [1:0][31:0]            cmag;
		logic [1:0][20:0]            q;
		logic signed [21:0]          x1;
		logic signed [21:0]          y1;
		logic signed [23:0]          x2;
		logic signed [23:0]          y2;
		logic signed [23:0]          xy;
		logic signed [24:0]          r2;
		logic signed [27:0]          r4;
		logic signed [25:0]          tx;
		logic signed [25:0]          ty;
		logic signed [39:0]          ka;
		logic signed [39:0]          kb;
		logic signed [37:0]          ta;
		logic signed [37:0]          tb;
		logic signed [37:0]          tc;
		logic signed [37:0]          td;
		logic signed [40:0]          f;
		logic signed [39:0]          rxt;
		logic signed [39:0]          ryt;
		logic signed [42:0]          xf;
		logic signed [42:0]          yf;
		logic signed [31:0]          rx;
		logic signed [31:0]          ry;
		logic signed [43:0]          fxr;
		logic signed [43:0]          fyr;
		logic [31:0]                 pxm;
		logic [31:0]                 pym;
		logic [31:0]                 wdm;
		logic [31:0]                 htm;
		logic [16:0]                 qu;
		logic [16:0]                 qv;
	} fpuv_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > S32_MAX) begin
			return 32'sh7FFFFFFF;
		end
		if (v < S32_MIN) begin
			return 32'sh80000000;
		end
		return 32'(v);
	endfunction

endpackage

FILE: hw/rtl/fpuv_if.sv
// ----------------------------------------------------------------------------
// fpuv channel interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fpuv_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [1:0]         cam;
	logic [4:0]         coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, func, cam, coef_index, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, func, cam, coef_index, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

interface fpuv_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] tex_u;
	logic [15:0] tex_v;
	logic        in_view;

	modport source (output valid, tex_u, tex_v, in_view, input ready);
	modport sink (input valid, tex_u, tex_v, in_view, output ready);
endinterface

interface fpuv_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] half_wheelbase;

	modport source (output valid, half_wheelbase, input ready);
	modport sink (input valid, half_wheelbase, output ready);
endinterface

FILE: hw/rtl/fpuv_coef_bank.sv
// ----------------------------------------------------------------------------
// fpuv_coef_bank
// per-slot calibration stores indexed by camera, registered read of all slots
// ----------------------------------------------------------------------------
module fpuv_coef_bank (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [1:0]                            rd_cam,
	input  logic                                  wr_en,
	input  logic [1:0]                            wr_cam,
	input  logic [4:0]                            wr_slot,
	input  logic [31:0]                           wr_data,
	output logic [fpuv_pkg::USED_SLOTS-1:0][31:0] rd_w
);
	import fpuv_pkg::*;

	logic     wr_ok;
	cam_idx_t wr_idx;
	cam_idx_t rd_idx;

	// slots past the used range are never read, so they are not kept
	assign wr_ok  = wr_en && (32'(wr_cam) < NUM_CAMERAS) && (32'(wr_slot) < COEF_SLOTS);
	assign wr_idx = cam_idx_t'(wr_cam);
	assign rd_idx = cam_idx_t'(rd_cam);

	for (genvar s = 0; s < USED_SLOTS; s++) begin : g_slot
		logic [31:0] mem [NUM_CAMERAS];

		always_ff @(posedge clk) begin
			if (wr_ok && (wr_slot == 5'(s))) begin
				mem[wr_idx] <= wr_data;
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rd_w[s] <= mem[rd_idx];
			end
		end
	end

endmodule

FILE: hw/rtl/fpuv_isqrt.sv
// ----------------------------------------------------------------------------
// fpuv_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module fpuv_isqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  fpuv_pkg::fpuv_item_t in_it,
	output logic                 out_vld,
	output fpuv_pkg::fpuv_item_t out_it
);
	import fpuv_pkg::*;

	logic        vld_s  [SQRT_STEPS];
	fpuv_item_t  it_s   [SQRT_STEPS];
	logic [63:0] rem_s  [SQRT_STEPS];
	logic [63:0] root_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
		logic        v_in;
		fpuv_item_t  i_in;
		logic [63:0] n_in;
		logic [63:0] r_in;
		logic [63:0] n_nx;
		logic [63:0] r_nx;
		logic [63:0] trial;

		if (k == 0) begin : g_first
			assign v_in = in_vld;
			assign i_in = in_it;
			assign n_in = in_it.sq;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign i_in = it_s[k-1];
			assign n_in = rem_s[k-1];
			assign r_in = root_s[k-1];
		end

		always_comb begin
			trial = r_in + BIT;
			if (n_in >= trial) begin
				n_nx = n_in - trial;
				r_nx = (r_in >> 1) + BIT;
			end else begin
				n_nx = n_in;
				r_nx = r_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k]   <= i_in;
				rem_s[k]  <= n_nx;
				root_s[k] <= r_nx;
			end
		end
	end

	assign out_vld = vld_s[SQRT_STEPS-1];

	always_comb begin
		out_it      = it_s[SQRT_STEPS-1];
		out_it.root = root_s[SQRT_STEPS-1][31:0];
	end

endmodule

FILE: hw/rtl/fpuv_xy_div.sv
// ----------------------------------------------------------------------------
// fpuv_xy_div
// pipelined restoring divider for the unified model quotients x1 and y1
// ----------------------------------------------------------------------------
module fpuv_xy_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  fpuv_pkg::fpuv_item_t in_it,
	output logic                 out_vld,
	output fpuv_pkg::fpuv_item_t out_it
);
	import fpuv_pkg::*;

	logic             vld_s [XDIV_STEPS];
	fpuv_item_t       it_s  [XDIV_STEPS];
	logic [1:0][51:0] rem_s [XDIV_STEPS];

	for (genvar k = 0; k < XDIV_STEPS; k++) begin : g_step
		localparam int J = XDIV_STEPS - 1 - k;
		logic             v_in;
		fpuv_item_t       i_in;
		fpuv_item_t       i_nx;
		logic [1:0][51:0] r_in;
		logic [1:0][51:0] r_nx;
		logic [66:0]      sub;

		if (k == 0) begin : g_first
			assign v_in = in_vld;
			assign i_in = in_it;
			assign r_in = {{in_it.cmag[1], 20'd0}, {in_it.cmag[0], 20'd0}};
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign i_in = it_s[k-1];
			assign r_in = rem_s[k-1];
		end

		always_comb begin
			i_nx = i_in;
			r_nx = r_in;
			sub  = 67'(i_in.dmag) << J;
			for (int a = 0; a < 2; a++) begin
				if (67'(r_in[a]) >= sub) begin
					r_nx[a]    = r_in[a] - sub[51:0];
					i_nx.q[a][J] = 1'b1;
				end else begin
					i_nx.q[a][J] = 1'b0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k]  <= i_nx;
				rem_s[k] <= r_nx;
			end
		end
	end

	assign out_vld = vld_s[XDIV_STEPS-1];
	assign out_it  = it_s[XDIV_STEPS-1];

endmodule

FILE: hw/rtl/fpuv_uv_div.sv
// ----------------------------------------------------------------------------
// fpuv_uv_div
// pipelined restoring divider for the pixel to uv normalisation
// ----------------------------------------------------------------------------
module fpuv_uv_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  fpuv_pkg::fpuv_item_t in_it,
	output logic                 out_vld,
	output fpuv_pkg::fpuv_item_t out_it
);
	import fpuv_pkg::*;

	logic             vld_s [UDIV_STEPS];
	fpuv_item_t       it_s  [UDIV_STEPS];
	logic [1:0][47:0] rem_s [UDIV_STEPS];

	for (genvar k = 0; k < UDIV_STEPS; k++) begin : g_step
		localparam int J = UDIV_STEPS - 1 - k;
		logic             v_in;
		fpuv_item_t       i_in;
		fpuv_item_t       i_nx;
		logic [1:0][47:0] r_in;
		logic [1:0][47:0] r_nx;
		logic [48:0]      sub_u;
		logic [48:0]      sub_v;

		// u is scaled by 2^16, v by 2^14 (quarter band)
		if (k == 0) begin : g_first
			assign v_in = in_vld;
			assign i_in = in_it;
			assign r_in = {{2'd0, in_it.pym, 14'd0}, {in_it.pxm, 16'd0}};
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign i_in = it_s[k-1];
			assign r_in = rem_s[k-1];
		end

		always_comb begin
			i_nx  = i_in;
			r_nx  = r_in;
			sub_u = 49'(i_in.wdm) << J;
			sub_v = 49'(i_in.htm) << J;
			if (49'(r_in[0]) >= sub_u) begin
				r_nx[0]     = r_in[0] - sub_u[47:0];
				i_nx.qu[J] = 1'b1;
			end else begin
				i_nx.qu[J] = 1'b0;
			end
			if (49'(r_in[1]) >= sub_v) begin
				r_nx[1]     = r_in[1] - sub_v[47:0];
				i_nx.qv[J] = 1'b1;
			end else begin
				i_nx.qv[J] = 1'b0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k]  <= i_nx;
				rem_s[k] <= r_nx;
			end
		end
	end

	assign out_vld = vld_s[UDIV_STEPS-1];
	assign out_it  = it_s[UDIV_STEPS-1];

endmodule

FILE: hw/rtl/fisheye_point_to_uv_projector_core.sv
// ----------------------------------------------------------------------------
// fisheye_point_to_uv_projector_core
// unified camera model projection with brown distortion into a four band atlas
// ----------------------------------------------------------------------------
// a request beat with func low stores one calibration word for one camera and
// gives no result; a beat with func high projects a world point and gives one
// result beat. the pipeline takes one beat per cycle unless the output stalls,
// and a projection result beat passes through 87 register stages: 17
// arithmetic stages, a 32 stage square root, a 21 stage divider for the
// unified model quotients and a 17 stage divider for the uv normalisation.
// all stages move together on one enable, so a stalled result beat holds
// the whole pipe and nothing is lost. calibration words are read for the
// whole camera when the request beat is taken and travel with it, so later
// writes never disturb a projection in flight. half_wheelbase is taken on
// any cfg beat; write it while idle
// ----------------------------------------------------------------------------
module fisheye_point_to_uv_projector_core (
	input  logic        clk,
	input  logic        arst_n,
	fpuv_req_if.sink    req,
	fpuv_rsp_if.source  rsp,
	fpuv_cfg_if.sink    cfg
);
	import fpuv_pkg::*;

	logic en;

	// half wheelbase register
	logic signed [23:0] hwb_q;

	// stage registers
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic       vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic       vld_s17;
	fpuv_item_t it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;
	fpuv_item_t it_s9, it_s10, it_s11, it_s12, it_s13, it_s14, it_s15, it_s16;
	logic [1:0]         cam_s1;
	logic               bad_s1;
	logic signed [32:0] wx_s1;
	logic signed [31:0] wy_s1, wz_s1;
	logic [15:0]        u_s17, v_s17;
	logic               iv_s17;

	logic [USED_SLOTS-1:0][31:0] bank_w;

	// outputs of the iterative units
	logic       sq_vld, xd_vld, ud_vld;
	fpuv_item_t sq_it, xd_it, ud_it;

	// next values of each stage
	fpuv_item_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13, n14, n15, n16;

	// the whole pipe advances unless a finished beat waits at the output
	assign en        = !vld_s17 || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwb_q <= '0;
		end else if (cfg.valid) begin
			hwb_q <= cfg.half_wheelbase;
		end
	end

	// calibration store: written on accepted write beats, read on every advance
	fpuv_coef_bank u_bank (
		.clk     (clk),
		.rd_en   (en),
		.rd_cam  (req.cam),
		.wr_en   (req.valid && req.ready && (req.func == FUNC_WRITE)),
		.wr_cam  (req.cam),
		.wr_slot (req.coef_index),
		.wr_data (req.coef_value),
		.rd_w    (bank_w)
	);

	// ---- stage 1: point shift and calibration read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid && (req.func == FUNC_PROJECT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cam_s1 <= req.cam;
			bad_s1 <= !(32'(req.cam) < NUM_CAMERAS);
			wx_s1  <= 33'(req.point_x) + 33'(hwb_q);
			wy_s1  <= req.point_y;
			wz_s1  <= req.point_z;
		end
	end

	always_comb begin
		n1     = '0;
		n1.cam = cam_s1;
		n1.bad = bad_s1;
		n1.w   = bank_w;
		n1.wx  = wx_s1;
		n1.wy  = wy_s1;
		n1.wz  = wz_s1;
	end

	// ---- stage 2: view matrix products, each floored to q16.16
	always_comb begin
		logic signed [64:0] pa;
		logic signed [63:0] pb;
		logic signed [63:0] pc;
		n2 = n1;
		for (int r = 0; r < 3; r++) begin
			pa = $signed(n1.w[4*r]) * n1.wx;
			pb = $signed(n1.w[4*r+1]) * n1.wy;
			pc = $signed(n1.w[4*r+2]) * n1.wz;
			n2.prod[3*r]   = 45'(pa >>> FRAC);
			n2.prod[3*r+1] = 45'(pb >>> FRAC);
			n2.prod[3*r+2] = 45'(pc >>> FRAC);
			n2.tr[r]       = 28'($signed(n1.w[4*r+3]) >>> 4);
		end
	end

	// ---- stage 3: camera coordinates, saturated
	always_comb begin
		logic signed [46:0] s;
		n3 = it_s2;
		for (int r = 0; r < 3; r++) begin
			s = 47'($signed(it_s2.prod[3*r])) + 47'($signed(it_s2.prod[3*r+1]))
			  + 47'($signed(it_s2.prod[3*r+2])) + 47'($signed(it_s2.tr[r]));
			n3.c[r] = sat32(64'(s));
		end
	end

	// ---- stage 4: squares
	always_comb begin
		logic signed [63:0] p;
		n4 = it_s3;
		for (int r = 0; r < 3; r++) begin
			p = $signed(it_s3.c[r]) * $signed(it_s3.c[r]);
			n4.sq3[r] = p[62:0];
		end
	end

	// ---- stage 5: sum of squares
	always_comb begin
		n5    = it_s4;
		n5.sq = 64'(it_s4.sq3[0]) + 64'(it_s4.sq3[1]) + 64'(it_s4.sq3[2]);
	end

	fpuv_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.in_it   (it_s5),
		.out_vld (sq_vld),
		.out_it  (sq_it)
	);

	// ---- stage 6: xi times norm
	always_comb begin
		logic signed [64:0] p;
		n6     = sq_it;
		p      = $signed({1'b0, sq_it.root}) * $signed(sq_it.w[SLOT_XI]);
		n6.xip = 45'(p >>> FRAC);
	end

	// ---- stage 7: denominator, magnitudes and range checks
	always_comb begin
		logic signed [45:0] d;
		n7 = it_s6;
		d  = 46'($signed(it_s6.c[2])) + 46'(it_s6.xip);
		n7.dmag = d[45] ? 46'(-d) : 46'(d);
		for (int a = 0; a < 2; a++) begin
			n7.cmag[a] = it_s6.c[a][31] ? 32'(-$signed(it_s6.c[a])) : it_s6.c[a];
			n7.neg[a]  = it_s6.c[a][31] ^ d[45];
		end
		// quotient of two or more in magnitude: off axis
		n7.bad = it_s6.bad || (d == '0)
		       || (47'(n7.cmag[0]) >= {n7.dmag, 1'b0})
		       || (47'(n7.cmag[1]) >= {n7.dmag, 1'b0});
	end

	fpuv_xy_div u_xy_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s7),
		.in_it   (it_s7),
		.out_vld (xd_vld),
		.out_it  (xd_it)
	);

	// ---- stage 8: signed quotients, truncated toward zero
	always_comb begin
		n8    = xd_it;
		n8.x1 = xd_it.neg[0] ? -$signed({1'b0, xd_it.q[0]}) : $signed({1'b0, xd_it.q[0]});
		n8.y1 = xd_it.neg[1] ? -$signed({1'b0, xd_it.q[1]}) : $signed({1'b0, xd_it.q[1]});
	end

	// ---- stage 9: second order terms
	always_comb begin
		logic signed [43:0] pxx;
		logic signed [43:0] pyy;
		logic signed [43:0] pxy;
		n9    = it_s8;
		pxx   = it_s8.x1 * it_s8.x1;
		pyy   = it_s8.y1 * it_s8.y1;
		pxy   = it_s8.x1 * it_s8.y1;
		n9.x2 = 24'(pxx >>> FRAC);
		n9.y2 = 24'(pyy >>> FRAC);
		n9.xy = 24'(pxy >>> FRAC);
	end

	// ---- stage 10: r^2, r^4 and tangential radii
	always_comb begin
		logic signed [49:0] pr;
		n10    = it_s9;
		n10.r2 = 25'(it_s9.x2) + 25'(it_s9.y2);
		pr     = n10.r2 * n10.r2;
		n10.r4 = 28'(pr >>> FRAC);
		n10.tx = 26'(n10.r2) + 26'(it_s9.x2) + 26'(it_s9.x2);
		n10.ty = 26'(n10.r2) + 26'(it_s9.y2) + 26'(it_s9.y2);
	end

	// ---- stage 11: distortion coefficient products
	always_comb begin
		logic signed [56:0] pk1;
		logic signed [59:0] pk2;
		logic signed [55:0] pt1;
		logic signed [57:0] pt2;
		logic signed [55:0] pt3;
		logic signed [57:0] pt4;
		n11    = it_s10;
		pk1    = $signed(it_s10.w[SLOT_K1]) * it_s10.r2;
		pk2    = $signed(it_s10.w[SLOT_K2]) * it_s10.r4;
		pt1    = $signed(it_s10.w[SLOT_P1]) * it_s10.xy;
		pt2    = $signed(it_s10.w[SLOT_P2]) * it_s10.tx;
		pt3    = $signed(it_s10.w[SLOT_P2]) * it_s10.xy;
		pt4    = $signed(it_s10.w[SLOT_P1]) * it_s10.ty;
		n11.ka = 40'(pk1 >>> FRAC);
		n11.kb = 40'(pk2 >>> FRAC);
		n11.ta = 38'(pt1 >>> FRAC);
		n11.tb = 38'(pt2 >>> FRAC);
		n11.tc = 38'(pt3 >>> FRAC);
		n11.td = 38'(pt4 >>> FRAC);
	end

	// ---- stage 12: radial factor and tangential sums
	always_comb begin
		n12     = it_s11;
		n12.f   = 41'sd1048576 + 41'(it_s11.ka) + 41'(it_s11.kb);
		n12.rxt = 40'(it_s11.ta) + 40'(it_s11.ta) + 40'(it_s11.tb);
		n12.ryt = 40'(it_s11.tc) + 40'(it_s11.tc) + 40'(it_s11.td);
	end

	// ---- stage 13: radial scaling
	always_comb begin
		logic signed [62:0] pfx;
		logic signed [62:0] pfy;
		n13    = it_s12;
		pfx    = it_s12.x1 * it_s12.f;
		pfy    = it_s12.y1 * it_s12.f;
		n13.xf = 43'(pfx >>> FRAC);
		n13.yf = 43'(pfy >>> FRAC);
	end

	// ---- stage 14: distorted coordinates, saturated to q12.20
	always_comb begin
		n14    = it_s13;
		n14.rx = sat32(64'(it_s13.xf) + 64'(it_s13.rxt));
		n14.ry = sat32(64'(it_s13.yf) + 64'(it_s13.ryt));
	end

	// ---- stage 15: focal scaling
	always_comb begin
		logic signed [63:0] ppx;
		logic signed [63:0] ppy;
		n15     = it_s14;
		ppx     = $signed(it_s14.w[SLOT_FX]) * it_s14.rx;
		ppy     = $signed(it_s14.w[SLOT_FY]) * it_s14.ry;
		n15.fxr = 44'(ppx >>> FRAC);
		n15.fyr = 44'(ppy >>> FRAC);
	end

	// ---- stage 16: pixel coordinates, sign normalised against image size
	always_comb begin
		logic signed [45:0] px;
		logic signed [45:0] py;
		logic signed [45:0] pxs;
		logic signed [45:0] pys;
		logic               wneg;
		logic               hneg;
		n16  = it_s15;
		px   = 46'(it_s15.fxr) + 46'($signed(it_s15.w[SLOT_CX]));
		py   = 46'(it_s15.fyr) + 46'($signed(it_s15.w[SLOT_CY]));
		wneg = it_s15.w[SLOT_WD][31];
		hneg = it_s15.w[SLOT_HT][31];
		n16.wdm = wneg ? 32'(-$signed(it_s15.w[SLOT_WD])) : it_s15.w[SLOT_WD];
		n16.htm = hneg ? 32'(-$signed(it_s15.w[SLOT_HT])) : it_s15.w[SLOT_HT];
		pxs  = wneg ? -px : px;
		pys  = hneg ? -py : py;
		n16.pxm = pxs[31:0];
		n16.pym = pys[31:0];
		n16.bad = it_s15.bad || (it_s15.w[SLOT_WD] == '0) || (it_s15.w[SLOT_HT] == '0)
		        || pxs[45] || (pxs > $signed({14'd0, n16.wdm}))
		        || pys[45] || (pys > $signed({14'd0, n16.htm}));
	end

	// ---- stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (en) begin
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= sq_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= xd_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= ud_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2  <= n2;
			it_s3  <= n3;
			it_s4  <= n4;
			it_s5  <= n5;
			it_s6  <= n6;
			it_s7  <= n7;
			it_s8  <= n8;
			it_s9  <= n9;
			it_s10 <= n10;
			it_s11 <= n11;
			it_s12 <= n12;
			it_s13 <= n13;
			it_s14 <= n14;
			it_s15 <= n15;
			it_s16 <= n16;
		end
	end

	fpuv_uv_div u_uv_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s16),
		.in_it   (it_s16),
		.out_vld (ud_vld),
		.out_it  (ud_it)
	);

	// ---- stage 17: output register, saturation and atlas band offset
	always_ff @(posedge clk) begin
		logic [17:0] vsum;
		if (en) begin
			vsum = 18'(ud_it.qv) + 18'({ud_it.cam, 14'd0});
			if (ud_it.bad) begin
				u_s17  <= '0;
				v_s17  <= '0;
				iv_s17 <= 1'b0;
			end else begin
				u_s17  <= ud_it.qu[16] ? 16'hFFFF : ud_it.qu[15:0];
				v_s17  <= (vsum > 18'd65535) ? 16'hFFFF : vsum[15:0];
				iv_s17 <= 1'b1;
			end
		end
	end

	assign rsp.valid   = vld_s17;
	assign rsp.tex_u   = u_s17;
	assign rsp.tex_v   = v_s17;
	assign rsp.in_view = iv_s17;

endmodule

FILE: hw/rtl/fpuv_chk.sv
// ----------------------------------------------------------------------------
// fpuv_chk
// port level checks of the projector core, bound to the top level
// ----------------------------------------------------------------------------
module fpuv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] tex_u,
	input logic [15:0] tex_v,
	input logic        in_view,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result beat stays and keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(tex_u) && $stable(tex_v)
			&& $stable(in_view))
		else $error("result beat changed while stalled");

	// out of view results carry zero coordinates
	a_zero_uv: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !in_view |-> tex_u == 16'd0 && tex_v == 16'd0)
		else $error("out of view result with nonzero uv");

	// with no result waiting the pipe always takes a request
	a_req_open: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty output");

	// request side only closes when a result is held back
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without output back pressure");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration beat refused");

endmodule

bind fisheye_point_to_uv_projector_core fpuv_chk u_fpuv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.tex_u     (rsp.tex_u),
	.tex_v     (rsp.tex_v),
	.in_view   (rsp.in_view),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

FILE: test/fisheye_point_to_uv_projector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisheye_point_to_uv_projector_core_tb
// self-checking bench: calibration writes and point projections are driven
// with random idling on both channels, each projection is predicted in
// fixed point and every result beat is compared in order with the prediction
// ----------------------------------------------------------------------------
module fisheye_point_to_uv_projector_core_tb;
	import fpuv_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		bit              func;
		bit [1:0]        cam;
		bit [4:0]        slot;
		bit signed [31:0] val;
		bit signed [31:0] px;
		bit signed [31:0] py;
		bit signed [31:0] pz;
	} req_beat_t;

	typedef struct {
		bit [15:0] u;
		bit [15:0] v;
		bit        vis;
	} uv_beat_t;

	localparam wide_t ONE_Q20   = wide_t'(1) <<< FRAC;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;

	fpuv_req_if req ();
	fpuv_rsp_if rsp ();
	fpuv_cfg_if cfg ();

	fisheye_point_to_uv_projector_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// predictor state: calibration words per camera and the wheelbase offset
	bit [31:0]  cal_words [NUM_CAMERAS][COEF_SLOTS];
	wide_t      wheel_off;

	req_beat_t  pending [$];
	uv_beat_t   uv_expected [$];
	req_beat_t  cur_beat;
	bit         beat_taken;
	bit         no_idle;
	int         n_writes, n_proj, n_visible, n_checked, n_errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic wide_t cal(input bit [1:0] cam, input int slot);
		return wide_t'($signed(cal_words[cam][slot]));
	endfunction

	function automatic wide_t clamp32(input wide_t v);
		if (v > wide_t'(S32_MAX)) begin
			return wide_t'(S32_MAX);
		end
		if (v < wide_t'(S32_MIN)) begin
			return wide_t'(S32_MIN);
		end
		return v;
	endfunction

	// floor square root, two bits per step
	function automatic bit [63:0] floor_root(input bit [63:0] n);
		bit [63:0] root;
		bit [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) begin
			b >>= 2;
		end
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic uv_beat_t project_point(input bit [1:0] cam, input wide_t wx,
			input wide_t wy, input wide_t wz);
		uv_beat_t  res;
		wide_t     c [3];
		wide_t     s, d, x1, y1, x2, y2, xy, r2, r4, f, rx, ry, pxq, pyq, wd, ht, uq, vq;
		bit [63:0] sq;
		bit [63:0] a;
		res = '{default: 0};
		sq = 0;
		for (int r = 0; r < 3; r++) begin
			s = ((cal(cam, 4 * r) * wx) >>> 20) + ((cal(cam, 4 * r + 1) * wy) >>> 20)
				+ ((cal(cam, 4 * r + 2) * wz) >>> 20) + (cal(cam, 4 * r + 3) >>> 4);
			c[r] = clamp32(s);
			a = (c[r] < 0) ? 64'(-c[r]) : 64'(c[r]);
			sq += a * a;
		end
		d = c[2] + (($signed({64'd0, floor_root(sq)}) * cal(cam, SLOT_XI)) >>> 20);
		// unified model denominator vanishes
		if (d == 0) begin
			return res;
		end
		x1 = (c[0] * ONE_Q20) / d;
		y1 = (c[1] * ONE_Q20) / d;
		// far off axis
		if (x1 >= 2 * ONE_Q20 || x1 <= -2 * ONE_Q20 || y1 >= 2 * ONE_Q20 || y1 <= -2 * ONE_Q20) begin
			return res;
		end
		x2 = (x1 * x1) >>> 20;
		y2 = (y1 * y1) >>> 20;
		xy = (x1 * y1) >>> 20;
		r2 = x2 + y2;
		r4 = (r2 * r2) >>> 20;
		f = ONE_Q20 + ((cal(cam, SLOT_K1) * r2) >>> 20) + ((cal(cam, SLOT_K2) * r4) >>> 20);
		rx = ((x1 * f) >>> 20) + 2 * ((cal(cam, SLOT_P1) * xy) >>> 20)
			+ ((cal(cam, SLOT_P2) * (r2 + 2 * x2)) >>> 20);
		ry = ((y1 * f) >>> 20) + 2 * ((cal(cam, SLOT_P2) * xy) >>> 20)
			+ ((cal(cam, SLOT_P1) * (r2 + 2 * y2)) >>> 20);
		rx = clamp32(rx);
		ry = clamp32(ry);
		pxq = ((cal(cam, SLOT_FX) * rx) >>> 20) + cal(cam, SLOT_CX);
		pyq = ((cal(cam, SLOT_FY) * ry) >>> 20) + cal(cam, SLOT_CY);
		wd = cal(cam, SLOT_WD);
		ht = cal(cam, SLOT_HT);
		if (wd == 0 || ht == 0) begin
			return res;
		end
		// negative image size: flip signs before dividing
		if (wd < 0) begin
			wd = -wd;
			pxq = -pxq;
		end
		if (ht < 0) begin
			ht = -ht;
			pyq = -pyq;
		end
		if (pxq < 0 || pxq > wd || pyq < 0 || pyq > ht) begin
			return res;
		end
		uq = (pxq * 65536) / wd;
		vq = (pyq * 16384) / ht + wide_t'(cam) * 16384;
		res.u = (uq > 65535) ? 16'hFFFF : 16'(uq);
		res.v = (vq > 65535) ? 16'hFFFF : 16'(vq);
		res.vis = 1'b1;
		return res;
	endfunction

	// one accepted request beat: store the word or queue the predicted uv
	function automatic void take_request(input req_beat_t b);
		if (b.func == FUNC_WRITE) begin
			cal_words[b.cam][b.slot] = b.val;
			n_writes++;
		end else begin
			uv_expected.insert(uv_expected.size(), project_point(b.cam,
				wide_t'(b.px) + wheel_off, wide_t'(b.py), wide_t'(b.pz)));
			n_proj++;
		end
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			take_request(cur_beat);
			beat_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || beat_taken) begin
				beat_taken = 1'b0;
				if (pending.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
					cur_beat = pending.pop_front();
					req.valid      <= 1'b1;
					req.func       <= cur_beat.func;
					req.cam        <= cur_beat.cam;
					req.coef_index <= cur_beat.slot;
					req.coef_value <= cur_beat.val;
					req.point_x    <= cur_beat.px;
					req.point_y    <= cur_beat.py;
					req.point_z    <= cur_beat.pz;
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= no_idle || ($urandom_range(99) >= 32);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		uv_beat_t exp_uv;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (uv_expected.size() == 0) begin
				$display("%0t: unexpected result beat u=%h v=%h in_view=%b", $realtime,
					rsp.tex_u, rsp.tex_v, rsp.in_view);
				n_errors++;
			end else begin
				exp_uv = uv_expected.pop_front();
				n_checked++;
				if (exp_uv.vis) begin
					n_visible++;
				end
				if (rsp.tex_u !== exp_uv.u) begin
					$display("%0t: tex_u expected %h actual %h", $realtime, exp_uv.u, rsp.tex_u);
					n_errors++;
				end
				if (rsp.tex_v !== exp_uv.v) begin
					$display("%0t: tex_v expected %h actual %h", $realtime, exp_uv.v, rsp.tex_v);
					n_errors++;
				end
				if (rsp.in_view !== exp_uv.vis) begin
					$display("%0t: in_view expected %b actual %b", $realtime, exp_uv.vis,
						rsp.in_view);
					n_errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic void push_write(input int cam, input int slot, input int val);
		req_beat_t b;
		b = '{func: FUNC_WRITE, cam: 2'(cam), slot: slot[4:0], val: val,
			px: $urandom, py: $urandom, pz: $urandom};
		pending.insert(pending.size(), b);
	endfunction

	function automatic void push_point(input int cam, input int x, input int y, input int z);
		req_beat_t b;
		b = '{func: FUNC_PROJECT, cam: 2'(cam), slot: 5'($urandom), val: $urandom,
			px: x, py: y, pz: z};
		pending.insert(pending.size(), b);
	endfunction

	// plausible calibration word for a slot, or now and then a raw one
	function automatic int cal_value(input int slot);
		int q20;
		q20 = 1 << 20;
		if ($urandom_range(7) == 0) begin
			return $urandom;
		end
		case (slot)
			0, 5, 10: begin
				return q20 + $signed($urandom_range(131072)) - 65536;
			end
			3, 7, 11: begin
				return $signed($urandom_range(2 * q20)) - q20;
			end
			SLOT_XI: begin
				return $urandom_range(q20 + q20 / 2);
			end
			SLOT_K1, SLOT_K2, SLOT_P1, SLOT_P2: begin
				return $signed($urandom_range(131072)) - 65536;
			end
			SLOT_FX, SLOT_FY: begin
				return $urandom_range(q20 / 3, q20 / 5);
			end
			SLOT_CX, SLOT_CY: begin
				return q20 / 2 + $signed($urandom_range(q20 / 8)) - q20 / 16;
			end
			SLOT_WD, SLOT_HT: begin
				return ($urandom_range(3) == 0) ? -q20 : q20;
			end
			default: begin
				if (slot < 12) begin
					return $signed($urandom_range(q20 / 4)) - q20 / 8;
				end
				return $urandom;
			end
		endcase
	endfunction

	// point in front of the camera, or a raw one
	function automatic void push_rand_point();
		int z;
		if ($urandom_range(7) == 0) begin
			push_point($urandom, $urandom, $urandom, $urandom);
		end else begin
			z = $urandom_range(8 << 16, 1 << 15);
			push_point($urandom, $signed($urandom_range(2 * z)) - z,
				$signed($urandom_range(2 * z)) - z, z);
		end
	endfunction

	task automatic drain();
		while (pending.size() != 0 || req.valid || uv_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_wheelbase(input logic signed [23:0] hw);
		@(negedge clk);
		cfg.valid          <= 1'b1;
		cfg.half_wheelbase <= hw;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		wheel_off = wide_t'(hw);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic signed [23:0] wheel_set [5];
		int q20;
		q20 = 1 << 20;
		wheel_set = '{24'sd0, 24'sh800000, 24'sh7FFFFF, 24'sd65536, 24'sd0};
		wheel_off = 0;
		beat_taken = 1'b0;
		no_idle = 1'b0;
		n_writes = 0;
		n_proj = 0;
		n_visible = 0;
		n_checked = 0;
		n_errors = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FUNC_WRITE;
		req.cam = '0;
		req.coef_index = '0;
		req.coef_value = '0;
		req.point_x = '0;
		req.point_y = '0;
		req.point_z = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.half_wheelbase = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_wheelbase(wheel_set[0]);

		// full calibration for every camera so no unwritten word is ever read
		for (int cm = 0; cm < NUM_CAMERAS; cm++) begin
			for (int sl = 0; sl < COEF_SLOTS; sl++) begin
				if (sl == 0 || sl == 5 || sl == 10) begin
					push_write(cm, sl, q20);
				end else if (sl < SLOT_XI) begin
					push_write(cm, sl, 0);
				end else if (sl == SLOT_FX || sl == SLOT_FY) begin
					push_write(cm, sl, q20 / 4);
				end else if (sl == SLOT_CX || sl == SLOT_CY) begin
					push_write(cm, sl, q20 / 2);
				end else if (sl == SLOT_WD || sl == SLOT_HT) begin
					push_write(cm, sl, q20);
				end else if (sl >= USED_SLOTS) begin
					// spare slots are written but never read
					push_write(cm, sl, $urandom);
				end else begin
					push_write(cm, sl, 0);
				end
			end
		end
		// camera 1: negative image size with mirrored principal point
		push_write(1, SLOT_WD, -q20);
		push_write(1, SLOT_HT, -q20);
		push_write(1, SLOT_CX, -q20 / 2);
		push_write(1, SLOT_CY, -q20 / 2);
		// camera 2: zero focal length with principal point on the far edge, uv exactly one
		push_write(2, SLOT_FX, 0);
		push_write(2, SLOT_FY, 0);
		push_write(2, SLOT_CX, q20);
		push_write(2, SLOT_CY, q20);
		// camera 3: zero image width
		push_write(3, SLOT_WD, 0);

		// directed projections
		for (int cm = 0; cm < NUM_CAMERAS; cm++) begin
			push_point(cm, 0, 0, 1 << 16);
		end
		push_point(0, 0, 0, 0);                          // zero denominator
		push_point(0, 10 << 16, 0, 1 << 16);             // far off axis in x
		push_point(0, 0, -(10 << 16), 1 << 16);          // far off axis in y
		push_point(0, 1 << 16, 1 << 16, 1 << 16);        // in view, toward the image corner
		push_point(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		push_point(0, 32'h80000000, 32'h80000000, 32'h80000000);
		push_point(0, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
		push_point(1, 1 << 14, -(1 << 14), 1 << 16);
		push_point(2, 1 << 15, 1 << 15, 2 << 16);
		drain();

		// phases with different wheelbase settings; the sender waits for all
		// results before every register write
		for (int ph = 1; ph < 5; ph++) begin
			if (ph == 4) begin
				wheel_set[ph] = 24'($urandom);
			end
			write_wheelbase(wheel_set[ph]);
			no_idle = (ph == 2);
			for (int n = 0; n < 140; n++) begin
				if ($urandom_range(4) == 0) begin
					int sl;
					sl = $urandom_range(COEF_SLOTS - 1);
					push_write($urandom, sl, cal_value(sl));
				end else begin
					push_rand_point();
				end
			end
			drain();
		end
		no_idle = 1'b0;

		$display("covered %0d calibration writes and %0d projections, %0d in view",
			n_writes, n_proj, n_visible);
		$display("%0d result beats checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
